// ----- rtl/core/sn2_pkg.sv -----
// Shared types, constants and helper functions for the fractal simplex noise block.
`timescale 1ns / 1ps
package sn2_pkg;

   localparam int PERM_SIZE       = 256;
   localparam int PERM_AW         = $clog2(PERM_SIZE);
   localparam int DEF_MAX_OCTAVES = 8;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int V_W    = 45;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef logic signed [31:0]       q16_type;
   typedef logic signed [MUL_W-1:0]  opnd_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam logic [CSR_AW-1:0] CSR_INV_SCALE  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_RANGE_LOW  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_RANGE_HIGH = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_OCTAVES    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_BASE_FREQ  = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_BASE_AMPL  = 3'd5;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam opnd_type SKEW_F2   = 34'sd1572067139;
   localparam opnd_type UNSKEW_G2 = 34'sd907633386;

   localparam logic signed [39:0] ONE_Q32  = 40'sh01_0000_0000;
   localparam logic signed [39:0] G2_Q32   = 40'sd907633386;
   localparam logic signed [39:0] ONE_Q24  = 40'sd16777216;
   localparam logic signed [37:0] HALF_Q24 = 38'sd8388608;

   function automatic q16_type sat32(input prod_type v);
      q16_type r;
      if (v > 68'sh7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -68'sh8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [3:0] mod12(input logic [7:0] v);
      logic [15:0] p;
      logic [4:0]  q;
      logic [7:0]  m;
      p = 16'(v) * 16'd171;
      q = p[15:11];
      m = v - 8'(q) * 8'd12;
      return m[3:0];
   endfunction

   function automatic opnd_type grad_dot(input logic [3:0] g,
                                         input logic signed [31:0] dx,
                                         input logic signed [31:0] dy);
      opnd_type ex;
      opnd_type ey;
      opnd_type r;
      ex = {{2{dx[31]}}, dx};
      ey = {{2{dy[31]}}, dy};
      unique case (g)
         4'd0, 4'd8:  r = ex;
         4'd1, 4'd9:  r = -ex;
         4'd2:        r = ex - ey;
         4'd3:        r = -ex - ey;
         4'd4, 4'd10: r = ey;
         4'd5, 4'd11: r = -ey;
         4'd6:        r = ex + ey;
         4'd7:        r = ey - ex;
         default:     r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/simplex_noise_2d_fractal_top.sv -----
// Top level of the fractal 2D simplex noise evaluator: sequencer and datapath.
// Load word: accepted while idle, no result word.
// Evaluate word: processed octave by octave for K octaves (sum width SUM_W = 53 by default), with
//   the weight steps skipped for each corner outside its falloff radius (one shared multiplier,
//   one perm table read port, bit-serial final divide); ready again after the result is queued.
// One evaluation at a time; a finished result waits in the output register.
// Synchronous reset: table reads as identity, control and configuration registers take their defaults.
`timescale 1ns / 1ps
module simplex_noise_2d_fractal_top import sn2_pkg::*; #(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [7:0]        req_perm_index,
   input  logic [7:0]        req_perm_value,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [31:0] rsp_noise_value,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int K_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W = V_W + MAX_OCTAVES;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_FX   = 5'd1;
   localparam logic [4:0] ST_FY   = 5'd2;
   localparam logic [4:0] ST_SX   = 5'd3;
   localparam logic [4:0] ST_SY   = 5'd4;
   localparam logic [4:0] ST_PY   = 5'd5;
   localparam logic [4:0] ST_SK   = 5'd6;
   localparam logic [4:0] ST_CI   = 5'd7;
   localparam logic [4:0] ST_TG   = 5'd8;
   localparam logic [4:0] ST_X0   = 5'd9;
   localparam logic [4:0] ST_RA   = 5'd10;
   localparam logic [4:0] ST_RB   = 5'd11;
   localparam logic [4:0] ST_RC   = 5'd12;
   localparam logic [4:0] ST_DX   = 5'd13;
   localparam logic [4:0] ST_DY   = 5'd14;
   localparam logic [4:0] ST_TT   = 5'd15;
   localparam logic [4:0] ST_T2   = 5'd16;
   localparam logic [4:0] ST_T4   = 5'd17;
   localparam logic [4:0] ST_ACC  = 5'd18;
   localparam logic [4:0] ST_OR   = 5'd19;
   localparam logic [4:0] ST_OV   = 5'd20;
   localparam logic [4:0] ST_DIV  = 5'd21;
   localparam logic [4:0] ST_OUT  = 5'd22;

   // configuration
   logic [31:0] inv_ff;
   q16_type     rlo_ff;
   q16_type     rhi_ff;
   logic [3:0]  oct_ff;
   logic [31:0] bfreq_ff;

   logic [4:0]       state_ff, state_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   q16_type          x_ff, x_in, y_ff, y_in;
   q16_type          fx_ff, fx_in, fy_ff, fy_in;
   q16_type          px_ff, px_in, py_ff, py_in;
   logic signed [20:0] ci_ff, ci_in, cj_ff, cj_in;
   logic signed [39:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [1:0]       gsel_ff, gsel_in, csel_ff, csel_in;
   logic [3:0]       grad_ff [3];
   logic [3:0]       grad_in [3];
   logic signed [35:0] sqx_ff, sqx_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   q16_type          rsp_data_ff, rsp_data_in;

   logic [PERM_SIZE-1:0] pvalid_ff;
   logic [PERM_AW-1:0]   rd_addr;
   logic [PERM_AW-1:0]   raddr_ff;
   logic                 rvalid_ff;
   logic [7:0]           ram_q;
   logic [7:0]           perm_rd;
   logic                 perm_we;

   opnd_type op_a, op_b;
   prod_type prod;

   logic                    div_start;
   logic                    div_done;
   logic signed [SUM_W-1:0] div_q;
   logic [MAX_OCTAVES-1:0]  div_den;
   logic                    u_div_idle_ff;

   logic [4:0]          sh;
   logic signed [52:0]  xs, ys;
   logic signed [55:0]  x0_full, y0_full;
   logic                i1;
   logic signed [39:0]  cdx40, cdy40;
   logic signed [31:0]  cdx, cdy;
   logic signed [37:0]  tval;
   logic signed [39:0]  acc40, n40, r40;
   logic signed [V_W-1:0] vval;
   logic [CNT_W-1:0]    wsh;
   logic [7:0]          jofs, iofs;
   logic                last_oct;
   logic                next_corner_end;

   assign perm_we = (state_ff == ST_IDLE) && req_valid && (req_cmd == CMD_LOAD);

   sn2_ram #(
      .WIDTH (8),
      .DEPTH (PERM_SIZE)
   ) u_perm (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (req_perm_index),
      .wr_data (req_perm_value),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   sn2_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   sn2_div #(
      .NUM_W (SUM_W),
      .DEN_W (MAX_OCTAVES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign perm_rd = rvalid_ff ? ram_q : raddr_ff;
   assign div_den = MAX_OCTAVES'(({{MAX_OCTAVES{1'b0}}, 1'b1} << cnt_ff) - 1'b1);

   always_comb begin
      sh      = 5'd16 - 5'(k_ff);
      xs      = {{5{px_ff[31]}}, px_ff, 16'b0} + {prod[67], prod[67:16]};
      ys      = {{5{py_ff[31]}}, py_ff, 16'b0} + {prod[67], prod[67:16]};
      x0_full = {{8{px_ff[31]}}, px_ff, 16'b0} - {{3{ci_ff[20]}}, ci_ff, 32'b0} + prod[55:0];
      y0_full = {{8{py_ff[31]}}, py_ff, 16'b0} - {{3{cj_ff[20]}}, cj_ff, 32'b0} + prod[55:0];
      i1      = (x0_ff > y0_ff);
      unique case (csel_ff)
         2'd0: begin
            cdx40 = x0_ff;
            cdy40 = y0_ff;
         end
         2'd1: begin
            cdx40 = x0_ff - (i1 ? ONE_Q32 : 40'sd0) + G2_Q32;
            cdy40 = y0_ff - (i1 ? 40'sd0 : ONE_Q32) + G2_Q32;
         end
         default: begin
            cdx40 = x0_ff - ONE_Q32 + G2_Q32 + G2_Q32;
            cdy40 = y0_ff - ONE_Q32 + G2_Q32 + G2_Q32;
         end
      endcase
      cdx   = cdx40[39:8];
      cdy   = cdy40[39:8];
      tval  = HALF_Q24 - {{2{sqx_ff[35]}}, sqx_ff} - {{2{prod[59]}}, prod[59:24]};
      acc40 = {{8{acc_ff[31]}}, acc_ff};
      n40   = (acc40 <<< 6) + (acc40 <<< 2) + (acc40 <<< 1);
      r40   = (n40 + ONE_Q24) >>> 1;
      vval  = {{13{rlo_ff[31]}}, rlo_ff} + {prod[67], prod[67:24]};
      wsh   = cnt_ff - 1'b1 - CNT_W'(k_ff);
      unique case (gsel_ff)
         2'd0: begin
            jofs = 8'd0;
            iofs = 8'd0;
         end
         2'd1: begin
            jofs = {7'd0, ~i1};
            iofs = {7'd0, i1};
         end
         default: begin
            jofs = 8'd1;
            iofs = 8'd1;
         end
      endcase
      last_oct        = ((CNT_W'(k_ff) + 1'b1) == cnt_ff);
      next_corner_end = (csel_ff == 2'd2);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      gsel_in      = gsel_ff;
      csel_in      = csel_ff;
      grad_in      = grad_ff;
      sqx_in       = sqx_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      op_a         = '0;
      op_b         = '0;
      rd_addr      = '0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_cmd == CMD_EVAL)) begin
               x_in   = req_x_coord;
               y_in   = req_y_coord;
               k_in   = '0;
               sum_in = '0;
               if (oct_ff == 4'd0) begin
                  cnt_in = CNT_W'(1);
               end else if (int'(oct_ff) > MAX_OCTAVES) begin
                  cnt_in = CNT_W'(MAX_OCTAVES);
               end else begin
                  cnt_in = CNT_W'(oct_ff);
               end
               state_in = ST_FX;
            end
         end
         ST_FX: begin
            op_a     = {{2{x_ff[31]}}, x_ff};
            op_b     = {2'b0, bfreq_ff};
            state_in = ST_FY;
         end
         ST_FY: begin
            fx_in    = sat32(prod >>> sh);
            op_a     = {{2{y_ff[31]}}, y_ff};
            op_b     = {2'b0, bfreq_ff};
            state_in = ST_SX;
         end
         ST_SX: begin
            fy_in    = sat32(prod >>> sh);
            op_a     = {{2{fx_ff[31]}}, fx_ff};
            op_b     = {2'b0, inv_ff};
            state_in = ST_SY;
         end
         ST_SY: begin
            px_in    = sat32(prod >>> 16);
            op_a     = {{2{fy_ff[31]}}, fy_ff};
            op_b     = {2'b0, inv_ff};
            state_in = ST_PY;
         end
         ST_PY: begin
            py_in    = sat32(prod >>> 16);
            state_in = ST_SK;
         end
         ST_SK: begin
            op_a     = {{2{px_ff[31]}}, px_ff} + {{2{py_ff[31]}}, py_ff};
            op_b     = SKEW_F2;
            state_in = ST_CI;
         end
         ST_CI: begin
            ci_in    = xs[52:32];
            cj_in    = ys[52:32];
            state_in = ST_TG;
         end
         ST_TG: begin
            op_a     = {{13{ci_ff[20]}}, ci_ff} + {{13{cj_ff[20]}}, cj_ff};
            op_b     = UNSKEW_G2;
            state_in = ST_X0;
         end
         ST_X0: begin
            x0_in    = x0_full[39:0];
            y0_in    = y0_full[39:0];
            gsel_in  = 2'd0;
            csel_in  = 2'd0;
            acc_in   = '0;
            state_in = ST_RA;
         end
         ST_RA: begin
            rd_addr  = cj_ff[7:0] + jofs;
            state_in = ST_RB;
         end
         ST_RB: begin
            rd_addr  = ci_ff[7:0] + iofs + perm_rd;
            state_in = ST_RC;
         end
         ST_RC: begin
            grad_in[gsel_ff] = mod12(perm_rd);
            if (gsel_ff == 2'd2) begin
               state_in = ST_DX;
            end else begin
               gsel_in  = gsel_ff + 1'b1;
               state_in = ST_RA;
            end
         end
         ST_DX: begin
            op_a     = {{2{cdx[31]}}, cdx};
            op_b     = {{2{cdx[31]}}, cdx};
            state_in = ST_DY;
         end
         ST_DY: begin
            sqx_in   = prod[59:24];
            op_a     = {{2{cdy[31]}}, cdy};
            op_b     = {{2{cdy[31]}}, cdy};
            state_in = ST_TT;
         end
         ST_TT: begin
            op_a = tval[33:0];
            op_b = tval[33:0];
            if (tval[37]) begin
               csel_in  = csel_ff + 1'b1;
               state_in = next_corner_end ? ST_OR : ST_DX;
            end else begin
               state_in = ST_T2;
            end
         end
         ST_T2: begin
            op_a     = prod[57:24];
            op_b     = prod[57:24];
            state_in = ST_T4;
         end
         ST_T4: begin
            op_a     = prod[57:24];
            op_b     = grad_dot(grad_ff[csel_ff], cdx, cdy);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + prod[55:24];
            csel_in  = csel_ff + 1'b1;
            state_in = next_corner_end ? ST_OR : ST_DX;
         end
         ST_OR: begin
            op_a     = {{2{rhi_ff[31]}}, rhi_ff} - {{2{rlo_ff[31]}}, rlo_ff};
            op_b     = r40[33:0];
            state_in = ST_OV;
         end
         ST_OV: begin
            sum_in = sum_ff + ({{MAX_OCTAVES{vval[V_W-1]}}, vval} <<< wsh);
            if (last_oct) begin
               state_in = ST_DIV;
            end else begin
               k_in     = K_W'(k_ff + 1'b1);
               state_in = ST_FX;
            end
         end
         ST_DIV: begin
            div_start = (u_div_idle_ff);
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat32({{(PROD_W-SUM_W){div_q[SUM_W-1]}}, div_q});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // start the divider on the first cycle in the divide state
   always_ff @(posedge clock) begin
      if (reset) begin
         u_div_idle_ff <= 1'b1;
      end else if (state_ff == ST_DIV) begin
         u_div_idle_ff <= 1'b0;
      end else begin
         u_div_idle_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pvalid_ff    <= '0;
         k_ff         <= '0;
         cnt_ff       <= CNT_W'(1);
         gsel_ff      <= '0;
         csel_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         gsel_ff      <= gsel_in;
         csel_ff      <= csel_in;
         if (perm_we) begin
            pvalid_ff[req_perm_index] <= 1'b1;
         end
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      ci_ff       <= ci_in;
      cj_ff       <= cj_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      grad_ff     <= grad_in;
      sqx_ff      <= sqx_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      raddr_ff    <= rd_addr;
      rvalid_ff   <= pvalid_ff[rd_addr];
   end

   // base amplitude cancels in the weighted average: no storage
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff   <= 32'd65536;
         rlo_ff   <= 32'sd0;
         rhi_ff   <= 32'sd65536;
         oct_ff   <= 4'd1;
         bfreq_ff <= 32'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_SCALE:  inv_ff   <= csr_wdata;
            CSR_RANGE_LOW:  rlo_ff   <= csr_wdata;
            CSR_RANGE_HIGH: rhi_ff   <= csr_wdata;
            CSR_OCTAVES:    oct_ff   <= csr_wdata[3:0];
            CSR_BASE_FREQ:  bfreq_ff <= csr_wdata;
            CSR_BASE_AMPL: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_data_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result word raised outside the output state");

   a_octave_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FX) |-> (CNT_W'(k_ff) < cnt_ff))
      else $error("octave index beyond octave count");

endmodule

// ----- rtl/core/sn2_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sn2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sn2_mul.sv -----
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module sn2_mul import sn2_pkg::*; (
   input  logic     clock,
   input  opnd_type op_a,
   input  opnd_type op_b,
   output prod_type prod
);

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/sn2_div.sv -----
// Bit-serial signed divider by a small unsigned divisor, truncating toward zero.
`timescale 1ns / 1ps
module sn2_div import sn2_pkg::*; #(
   parameter int NUM_W = 53,
   parameter int DEN_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic                    done,
   output logic signed [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_t;
   logic             qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rem_t   = {rem_ff, mag_ff[NUM_W-1]};
      qbit    = (rem_t >= {1'b0, den_ff});
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[NUM_W-1];
         mag_in  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
      end else if (busy_ff) begin
         rem_in = qbit ? DEN_W'(rem_t - {1'b0, den_ff}) : rem_t[DEN_W-1:0];
         mag_in = {mag_ff[NUM_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'(mag_ff) : signed'(mag_ff);

endmodule
